[sv/cp_interrupter_offsample_controller_top_defines.svh]
// Assertion macros for the current-interrupter controller.
// Define ASSERT_OFF to compile all checks out.
`ifndef CP_INTERRUPTER_OFFSAMPLE_CONTROLLER_TOP_DEFINES_SVH
`define CP_INTERRUPTER_OFFSAMPLE_CONTROLLER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, suspended while reset is high
`define CPIO_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked property, also checked during reset
`define CPIO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CPIO_ASSERT(lbl, clk, rst, prop, msg)
`define CPIO_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/cpio_pkg.sv]
// Shared types and constants of the current-interrupter controller.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package cpio_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

   localparam logic [15:0]        ON_TIME_RESET    = 16'd4000;
   localparam logic [15:0]        OFF_TIME_RESET   = 16'd1000;
   localparam logic [15:0]        CAPTURE_RESET    = 16'd300;
   localparam logic [15:0]        TEST_TIME_RESET  = 16'd1000;
   localparam logic signed [15:0] THRESHOLD_RESET  = -16'sd8500;
   localparam logic [15:0]        STRAY_RESET      = 16'd3000;
   localparam logic signed [15:0] HELD_ON_RESET    = -16'sd12800;
   localparam logic signed [15:0] HELD_OFF_RESET   = -16'sd11000;
   localparam logic [15:0]        HELD_IR_RESET    = 16'd1800;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_SAMPLE = 3'd1,
      CMD_START  = 3'd2,
      CMD_STOP   = 3'd3,
      CMD_TEST   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_ON_TIME   = 3'd0,
      CSR_OFF_TIME  = 3'd1,
      CSR_CAPTURE   = 3'd2,
      CSR_TEST_TIME = 3'd3,
      CSR_THRESHOLD = 3'd4,
      CSR_STRAY     = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      SYS_PROTECTED = 3'd0,
      SYS_UNDER     = 3'd1,
      SYS_STRAY     = 3'd2,
      SYS_TEST      = 3'd3,
      SYS_CYCLING   = 3'd4
   } sys_state_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ON   = 2'd1,
      PH_OFF  = 2'd2
   } cycle_phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic signed [15:0] pipe_potential;
      logic [15:0]       coupon_density;
   } req_payload_type;

   typedef struct packed {
      logic              kind;
      logic              relay_on;
      logic [2:0]        system_state;
      logic signed [15:0] potential_out;
      logic [15:0]       density_out;
      logic signed [15:0] on_potential;
      logic signed [15:0] off_potential;
      logic [15:0]       ir_drop;
      logic              off_latched;
      logic [15:0]       sample_time_ms;
      logic              last;
   } rsp_payload_type;

   // one buffered sample
   typedef struct packed {
      logic              relay;
      logic [15:0]       time_ms;
      logic signed [15:0] pot;
      logic [15:0]       dens;
   } store_entry_type;

endpackage

[sv/cpio_req_if.sv]
// Request channel of the controller: valid/ready plus one command item.
// Depends on cpio_pkg.
`timescale 1ns / 1ps

interface cpio_req_if import cpio_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[sv/cpio_rsp_if.sv]
// Response channel of the controller: valid/ready plus one result item.
// Depends on cpio_pkg.
`timescale 1ns / 1ps

interface cpio_rsp_if import cpio_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[sv/cp_interrupter_offsample_controller_top.sv]
// Current-interrupter controller for cathodic protection: top level.
// Depends on cpio_pkg, cpio_req_if, cpio_rsp_if and the defines header.
//
// Usage:
//   req_ch carries commands: tick (1 ms), sample, start cycle, stop cycle,
//   single test. csr_we/csr_index/csr_wdata write the six timing and limit
//   registers; write them only while the block is idle.
//   rsp_ch carries results: one status result per sample, and a run of
//   buffered sample records when an off phase or a test ends.
// Output and throughput:
//   A status result sits in the output register the cycle after its request
//   is accepted. One request per cycle while rsp_ch.ready stays high; a
//   waiting result holds off new requests until the cycle it is taken.
//   A tick that ends an off phase or a test drains N buffered samples
//   (N up to 64), each record by a memory read into a register, then the
//   output load. No request is taken during the drain.
// Reset: synchronous, active high; registers return to defaults, the
//   buffer is empty, no clearing pass is needed.
// Stall: while rsp_ch.ready is low the result holds; every request and
//   every drain record waits until it is taken.
`timescale 1ns / 1ps

`include "cp_interrupter_offsample_controller_top_defines.svh"

module cp_interrupter_offsample_controller_top import cpio_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   cpio_req_if.sink          req_ch,
   cpio_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   // configuration
   logic [15:0]        on_time_ff, off_time_ff, capture_ff, test_time_ff, stray_ff;
   logic signed [15:0] threshold_ff;

   // controller state
   logic               relay_ff, relay_in;
   logic               cyc_active_ff, cyc_active_in;
   cycle_phase_type    cyc_phase_ff, cyc_phase_in;
   logic               test_active_ff, test_active_in;
   logic [15:0]        phase_timer_ff, phase_timer_in;
   logic [15:0]        test_timer_ff, test_timer_in;
   logic [15:0]        batch_timer_ff, batch_timer_in;
   logic               cap_done_ff, cap_done_in;
   logic signed [15:0] held_on_ff, held_on_in;
   logic signed [15:0] held_off_ff, held_off_in;
   logic [15:0]        held_ir_ff, held_ir_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   ctrl_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]  drain_idx_ff, drain_idx_in;
   logic [CNT_W-1:0]   drain_len_ff, drain_len_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   // sample memory
   store_entry_type    mem [BUFFER_DEPTH];
   store_entry_type    mem_q_ff;
   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   store_entry_type    mem_wdata;

   // request datapath helpers
   logic               accept, out_free, drain_hit, drain_last;
   logic [15:0]        pt_inc, tt_inc, off_dur;
   logic signed [15:0] pot;
   logic [15:0]        dens, dens_kept;
   logic signed [16:0] diff;
   logic [16:0]        diff_abs;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign accept     = req_ch.valid && req_ch.ready;
   assign pot        = req_ch.data.pipe_potential;
   assign dens       = req_ch.data.coupon_density;
   assign dens_kept  = relay_ff ? dens : 16'd0;
   assign pt_inc     = (phase_timer_ff == 16'hFFFF) ? phase_timer_ff : phase_timer_ff + 16'd1;
   assign tt_inc     = (test_timer_ff == 16'hFFFF) ? test_timer_ff : test_timer_ff + 16'd1;
   assign off_dur    = cyc_active_ff ? phase_timer_ff : (test_active_ff ? test_timer_ff : 16'd0);
   assign diff       = {held_on_ff[15], held_on_ff} - {pot[15], pot};
   assign diff_abs   = diff[16] ? 17'(-diff) : 17'(diff);
   assign drain_last = (CNT_W'(drain_idx_ff) == drain_len_ff - CNT_W'(1));

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         on_time_ff   <= ON_TIME_RESET;
         off_time_ff  <= OFF_TIME_RESET;
         capture_ff   <= CAPTURE_RESET;
         test_time_ff <= TEST_TIME_RESET;
         threshold_ff <= THRESHOLD_RESET;
         stray_ff     <= STRAY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ON_TIME:   on_time_ff   <= csr_wdata;
            CSR_OFF_TIME:  off_time_ff  <= csr_wdata;
            CSR_CAPTURE:   capture_ff   <= csr_wdata;
            CSR_TEST_TIME: test_time_ff <= csr_wdata;
            CSR_THRESHOLD: threshold_ff <= csr_wdata;
            CSR_STRAY:     stray_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sample memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_raddr];
      end
   end

   // next state and outputs
   always_comb begin
      relay_in       = relay_ff;
      cyc_active_in  = cyc_active_ff;
      cyc_phase_in   = cyc_phase_ff;
      test_active_in = test_active_ff;
      phase_timer_in = phase_timer_ff;
      test_timer_in  = test_timer_ff;
      batch_timer_in = batch_timer_ff;
      cap_done_in    = cap_done_ff;
      held_on_in     = held_on_ff;
      held_off_in    = held_off_ff;
      held_ir_in     = held_ir_ff;
      count_in       = count_ff;
      state_in       = state_ff;
      drain_idx_in   = drain_idx_ff;
      drain_len_in   = drain_len_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_in         = rsp_ff;
      mem_we         = 1'b0;
      mem_waddr      = ADDR_W'(count_ff);
      mem_wdata      = '{relay: relay_ff, time_ms: batch_timer_ff, pot: pot, dens: dens_kept};
      mem_re         = 1'b0;
      mem_raddr      = drain_idx_ff;
      drain_hit      = 1'b0;
      req_ch.ready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = out_free;
            if (accept) begin
               case (req_ch.data.cmd)
                  CMD_TICK: begin
                     phase_timer_in = pt_inc;
                     test_timer_in  = tt_inc;
                     batch_timer_in = batch_timer_ff + 16'd1;
                     if (cyc_active_ff) begin
                        if (cyc_phase_ff == PH_ON) begin
                           relay_in = 1'b1;
                           if (pt_inc >= on_time_ff) begin
                              cyc_phase_in   = PH_OFF;
                              phase_timer_in = 16'd0;
                              cap_done_in    = 1'b0;
                              relay_in       = 1'b0;
                           end
                        end else if (cyc_phase_ff == PH_OFF) begin
                           relay_in = 1'b0;
                           if (pt_inc >= off_time_ff) begin
                              drain_hit      = 1'b1;
                              cyc_phase_in   = PH_ON;
                              phase_timer_in = 16'd0;
                              batch_timer_in = 16'd0;
                              cap_done_in    = 1'b0;
                              relay_in       = 1'b1;
                           end
                        end
                     end
                     if (test_active_ff && !cyc_active_ff && tt_inc >= test_time_ff) begin
                        test_active_in = 1'b0;
                        relay_in       = 1'b1;
                        drain_hit      = 1'b1;
                     end
                     if (drain_hit) begin
                        count_in = '0;
                        if (count_ff != '0) begin
                           drain_len_in = count_ff;
                           drain_idx_in = '0;
                           state_in     = ST_READ;
                        end
                     end
                  end
                  CMD_SAMPLE: begin
                     if (relay_ff) begin
                        held_on_in = pot;
                     end else if (off_dur >= capture_ff && !cap_done_ff) begin
                        held_off_in = pot;
                        held_ir_in  = diff_abs[15:0];
                        cap_done_in = 1'b1;
                     end
                     if (count_ff < CNT_W'(BUFFER_DEPTH)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                     rsp_valid_in          = 1'b1;
                     rsp_in.kind           = 1'b0;
                     rsp_in.relay_on       = relay_ff;
                     rsp_in.potential_out  = pot;
                     rsp_in.density_out    = dens_kept;
                     rsp_in.on_potential   = held_on_in;
                     rsp_in.off_potential  = held_off_in;
                     rsp_in.ir_drop        = held_ir_in;
                     rsp_in.off_latched    = cap_done_in;
                     rsp_in.sample_time_ms = batch_timer_ff;
                     rsp_in.last           = 1'b1;
                     if (dens > stray_ff) begin
                        rsp_in.system_state = SYS_STRAY;
                     end else if (cyc_active_ff) begin
                        rsp_in.system_state = SYS_CYCLING;
                     end else if (test_active_ff) begin
                        rsp_in.system_state = SYS_TEST;
                     end else if (held_off_in <= threshold_ff) begin
                        rsp_in.system_state = SYS_PROTECTED;
                     end else begin
                        rsp_in.system_state = SYS_UNDER;
                     end
                  end
                  CMD_START: begin
                     cyc_active_in  = 1'b1;
                     cyc_phase_in   = PH_ON;
                     phase_timer_in = 16'd0;
                     batch_timer_in = 16'd0;
                     count_in       = '0;
                     cap_done_in    = 1'b0;
                     relay_in       = 1'b1;
                  end
                  CMD_STOP: begin
                     cyc_active_in = 1'b0;
                     cyc_phase_in  = PH_IDLE;
                     relay_in      = 1'b1;
                  end
                  CMD_TEST: begin
                     if (!test_active_ff && !cyc_active_ff) begin
                        test_active_in = 1'b1;
                        cap_done_in    = 1'b0;
                        test_timer_in  = 16'd0;
                        batch_timer_in = 16'd0;
                        count_in       = '0;
                        relay_in       = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = 1'b1;
               rsp_in.relay_on       = mem_q_ff.relay;
               rsp_in.system_state   = SYS_PROTECTED;
               rsp_in.potential_out  = mem_q_ff.pot;
               rsp_in.density_out    = mem_q_ff.dens;
               rsp_in.on_potential   = held_on_ff;
               rsp_in.off_potential  = held_off_ff;
               rsp_in.ir_drop        = held_ir_ff;
               rsp_in.off_latched    = 1'b0;
               rsp_in.sample_time_ms = mem_q_ff.time_ms;
               rsp_in.last           = drain_last;
               if (drain_last) begin
                  state_in = ST_IDLE;
               end else begin
                  drain_idx_in = drain_idx_ff + ADDR_W'(1);
                  state_in     = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff       <= 1'b1;
         cyc_active_ff  <= 1'b0;
         cyc_phase_ff   <= PH_IDLE;
         test_active_ff <= 1'b0;
         phase_timer_ff <= 16'd0;
         test_timer_ff  <= 16'd0;
         batch_timer_ff <= 16'd0;
         cap_done_ff    <= 1'b0;
         held_on_ff     <= HELD_ON_RESET;
         held_off_ff    <= HELD_OFF_RESET;
         held_ir_ff     <= HELD_IR_RESET;
         count_ff       <= '0;
         state_ff       <= ST_IDLE;
         drain_idx_ff   <= '0;
         drain_len_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         relay_ff       <= relay_in;
         cyc_active_ff  <= cyc_active_in;
         cyc_phase_ff   <= cyc_phase_in;
         test_active_ff <= test_active_in;
         phase_timer_ff <= phase_timer_in;
         test_timer_ff  <= test_timer_in;
         batch_timer_ff <= batch_timer_in;
         cap_done_ff    <= cap_done_in;
         held_on_ff     <= held_on_in;
         held_off_ff    <= held_off_in;
         held_ir_ff     <= held_ir_in;
         count_ff       <= count_in;
         state_ff       <= state_in;
         drain_idx_ff   <= drain_idx_in;
         drain_len_ff   <= drain_len_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // checks
   `CPIO_ASSERT(a_drain_idx_range, clock, reset, (state_ff != ST_IDLE) |-> (CNT_W'(drain_idx_ff) < drain_len_ff), "drain index beyond run length")
   `CPIO_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(BUFFER_DEPTH), "sample count beyond buffer depth")
   `CPIO_ASSERT(a_drain_clears, clock, reset, (state_ff == ST_IDLE && state_in == ST_READ) |=> (count_ff == '0), "buffer not emptied at drain start")
   `CPIO_ASSERT(a_last_ends, clock, reset, (state_ff == ST_SEND && out_free && drain_last) |=> (state_ff == ST_IDLE && rsp_ff.last && rsp_ff.kind), "final record does not end the drain")

endmodule
